// ===== hw/rtl/three_axis_second_order_lowpass_core_defines.svh =====
// Assertion macros shared by the low-pass filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef THREE_AXIS_SECOND_ORDER_LOWPASS_CORE_DEFINES_SVH
`define THREE_AXIS_SECOND_ORDER_LOWPASS_CORE_DEFINES_SVH

// Antecedent and consequent checked at the same clock edge.
`define TLP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent checked at the clock edge after the antecedent.
`define TLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/tlp_pkg.sv =====
// Package for the three-axis second-order low-pass filter.
// Holds widths, reset values, register codes and the coefficient type; depends on nothing.
package tlp_pkg;

   localparam int AXES               = 3;
   localparam int COEF_W             = 32;
   localparam int HIST_W             = 32;
   localparam int DEF_SAMPLE_WIDTH   = 16;
   localparam int DEF_COEF_FRAC_BITS = 30;
   localparam int CSR_ADDR_W         = 4;
   localparam int CSR_DATA_W         = 32;

   localparam logic signed [COEF_W-1:0] RST_FB_ONE = 32'sd2071735499;
   localparam logic signed [COEF_W-1:0] RST_FB_TWO = -32'sd1000494912;
   localparam logic signed [COEF_W-1:0] RST_GAIN   = 32'sd2501237;

   typedef enum logic [1:0] {
      REG_FB_ONE = 2'd0,
      REG_FB_TWO = 2'd1,
      REG_GAIN   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] fb_one;
      logic signed [COEF_W-1:0] fb_two;
      logic signed [COEF_W-1:0] gain;
   } coef_type;

endpackage

// ===== hw/rtl/tlp_lane.sv =====
// One axis of the filter: input gain product register, two-deep output history and
// the rounding and saturation of the new output. Depends on tlp_pkg.
module tlp_lane import tlp_pkg::*; #(
   parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  coef_type                       coef,
   input  logic                           load,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           advance,
   output logic signed [SAMPLE_WIDTH-1:0] filtered,
   output logic                           clip
);

   localparam int HIST_FRAC = HIST_W - SAMPLE_WIDTH;
   localparam int PROD_W    = COEF_W + HIST_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int GAIN_W    = COEF_W + SAMPLE_WIDTH;
   localparam int TOP_LSB   = COEF_FRAC_BITS + HIST_W - 1;
   localparam logic [SUM_W-1:0] HALF     = SUM_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [HIST_W:0]  OUT_HALF = (HIST_W + 1)'(1) << (HIST_FRAC - 1);

   logic signed [GAIN_W-1:0] gain_prod_ff, gain_prod_in;
   logic signed [HIST_W-1:0] last_ff, last_in;
   logic signed [HIST_W-1:0] older_ff, older_in;
   logic signed [PROD_W-1:0] fb_one_prod;
   logic signed [PROD_W-1:0] fb_two_prod;
   logic [SUM_W-1:0]         sum;
   logic [SUM_W-TOP_LSB-1:0] upper;
   logic                     hist_ovf;
   logic [HIST_W-1:0]        hist_val;
   logic [HIST_W:0]          out_sum;
   logic [SAMPLE_WIDTH:0]    out_int;
   logic                     out_ovf;

   assign gain_prod_in = coef.gain * sample;
   assign fb_one_prod  = coef.fb_one * last_ff;
   assign fb_two_prod  = coef.fb_two * older_ff;

   // Exact sum of the three products, rounded half up at the coefficient point.
   assign sum = {{2{fb_one_prod[PROD_W-1]}}, fb_one_prod}
              + {{2{fb_two_prod[PROD_W-1]}}, fb_two_prod}
              + {{2{gain_prod_ff[GAIN_W-1]}}, gain_prod_ff, {HIST_FRAC{1'b0}}}
              + HALF;

   assign upper    = sum[SUM_W-1:TOP_LSB];
   assign hist_ovf = !((&upper) || !(|upper));
   assign hist_val = hist_ovf ? {sum[SUM_W-1], {(HIST_W-1){~sum[SUM_W-1]}}}
                              : sum[TOP_LSB:COEF_FRAC_BITS];

   assign out_sum  = {hist_val[HIST_W-1], hist_val} + OUT_HALF;
   assign out_int  = out_sum[HIST_W:HIST_FRAC];
   assign out_ovf  = out_int[SAMPLE_WIDTH] ^ out_int[SAMPLE_WIDTH-1];
   assign filtered = out_ovf
                   ? {out_int[SAMPLE_WIDTH], {(SAMPLE_WIDTH-1){~out_int[SAMPLE_WIDTH]}}}
                   : out_int[SAMPLE_WIDTH-1:0];
   assign clip     = hist_ovf | out_ovf;

   assign last_in  = advance ? hist_val : last_ff;
   assign older_in = advance ? last_ff  : older_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         older_ff <= '0;
      end else begin
         last_ff  <= last_in;
         older_ff <= older_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gain_prod_ff <= gain_prod_in;
      end
   end

endmodule

// ===== hw/rtl/tlp_merge.sv =====
// Output stage: registers the lane outputs, merges the lane clip flags and holds
// the result beat while the receiver stalls. Depends on tlp_pkg.
module tlp_merge import tlp_pkg::*; #(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic signed [SAMPLE_WIDTH-1:0] lane_value [AXES],
   input  logic [AXES-1:0]                lane_clip,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] value [AXES],
   output logic                           saturated,
   output logic                           free
);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff [AXES];
   logic                           sat_ff, sat_in;

   assign free      = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign sat_in    = |lane_clip;
   assign rsp_valid = valid_ff;
   assign value     = value_ff;
   assign saturated = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= lane_value;
         sat_ff   <= sat_in;
      end
   end

endmodule

// ===== hw/rtl/three_axis_second_order_lowpass_core.sv =====
// Three-axis second-order all-pole low-pass filter, top level.
// Instantiates tlp_lane (one per axis) and tlp_merge; depends on tlp_pkg and the defines header.
//
// Each input beat on the req_ channel carries one signed sample per axis; each produces
// exactly one result beat on the rsp_ channel with the filtered samples and a flag that is
// set when any axis was clipped. A beat moves at a rising edge where valid is high and
// stall is low. While the receiver does not stall, the block takes one beat per cycle: an
// accepted beat has its gain product registered in the input stage; once the output register
// is free, the per-axis recursion (two feedback products plus the registered gain product,
// rounded and saturated) closes in the lanes and loads the output register, which offers
// the result. The feedback loop through the history registers of each lane sets the rate
// of one beat per cycle.
// When the receiver stalls, the result is held and the block goes on taking one further
// beat into its input stage, then stalls the sender until the output register frees.
// Synchronous reset empties both stages, clears the output history of every axis and
// loads the default coefficients. The user must write the coefficients through the csr_ port
// at byte addresses 0, 4 and 8, only while no beat is in flight; the block does not enforce it.
`include "three_axis_second_order_lowpass_core_defines.svh"

module three_axis_second_order_lowpass_core import tlp_pkg::*; #(
   parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_x,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_y,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_z,
   output logic                           rsp_saturated,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [CSR_DATA_W-1:0]          csr_pwdata,
   output logic [CSR_DATA_W-1:0]          csr_prdata,
   output logic                           csr_pready
);

   coef_type                       coef_ff, coef_in;
   reg_index_type                  reg_index;
   logic                           csr_write;
   logic                           stage_valid_ff, stage_valid_in;
   logic                           accept;
   logic                           advance;
   logic                           out_free;
   logic signed [SAMPLE_WIDTH-1:0] sample_arr [AXES];
   logic signed [SAMPLE_WIDTH-1:0] lane_value [AXES];
   logic [AXES-1:0]                lane_clip;
   logic signed [SAMPLE_WIDTH-1:0] out_value  [AXES];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      coef_in    = coef_ff;
      csr_prdata = '0;
      unique case (reg_index)
         REG_FB_ONE: begin
            csr_prdata = coef_ff.fb_one;
            if (csr_write) coef_in.fb_one = csr_pwdata;
         end
         REG_FB_TWO: begin
            csr_prdata = coef_ff.fb_two;
            if (csr_write) coef_in.fb_two = csr_pwdata;
         end
         REG_GAIN: begin
            csr_prdata = coef_ff.gain;
            if (csr_write) coef_in.gain = csr_pwdata;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.fb_one <= RST_FB_ONE;
         coef_ff.fb_two <= RST_FB_TWO;
         coef_ff.gain   <= RST_GAIN;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign advance        = stage_valid_ff && out_free;
   assign req_stall      = stage_valid_ff && !out_free;
   assign accept         = req_valid && !req_stall;
   assign stage_valid_in = accept || (stage_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign sample_arr[0] = req_sample_x;
   assign sample_arr[1] = req_sample_y;
   assign sample_arr[2] = req_sample_z;

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      tlp_lane #(
         .SAMPLE_WIDTH   (SAMPLE_WIDTH),
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .coef     (coef_ff),
         .load     (accept),
         .sample   (sample_arr[g]),
         .advance  (advance),
         .filtered (lane_value[g]),
         .clip     (lane_clip[g])
      );
   end

   tlp_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .lane_value (lane_value),
      .lane_clip  (lane_clip),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .value      (out_value),
      .saturated  (rsp_saturated),
      .free       (out_free)
   );

   assign rsp_filtered_x = out_value[0];
   assign rsp_filtered_y = out_value[1];
   assign rsp_filtered_z = out_value[2];

   `TLP_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid)
   `TLP_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, stage_valid_ff)
   `TLP_ASSERT_NEXT(a_blocked_stage_kept, clock, reset, stage_valid_ff && !out_free,
                    stage_valid_ff)
   `TLP_ASSERT_SAME(a_full_pipe_stalls, clock, reset,
                    stage_valid_ff && rsp_valid && rsp_stall, req_stall)

endmodule

// ===== verif/three_axis_second_order_lowpass_core_tb.sv =====
// Self-checking testbench for the three-axis second-order low-pass filter core.
// Predicts every result beat with a fixed-point model of the recursion and checks it.
// Depends on tlp_pkg and the three_axis_second_order_lowpass_core RTL.
`timescale 1ns / 100ps

module three_axis_second_order_lowpass_core_tb;
   import tlp_pkg::*;

   localparam int SW          = DEF_SAMPLE_WIDTH;
   localparam int CFB         = DEF_COEF_FRAC_BITS;
   localparam int HFB         = HIST_W - SW;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 4'd12;

   typedef struct packed {
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      logic signed [SW-1:0] z;
   } sample_beat_t;

   typedef struct packed {
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      logic signed [SW-1:0] z;
      logic                 sat;
   } filtered_beat_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [SW-1:0]  req_sample_x = '0;
   logic signed [SW-1:0]  req_sample_y = '0;
   logic signed [SW-1:0]  req_sample_z = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [SW-1:0]  rsp_filtered_x;
   logic signed [SW-1:0]  rsp_filtered_y;
   logic signed [SW-1:0]  rsp_filtered_z;
   logic                  rsp_saturated;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic signed [COEF_W-1:0] coef_fb_one = RST_FB_ONE;
   logic signed [COEF_W-1:0] coef_fb_two = RST_FB_TWO;
   logic signed [COEF_W-1:0] coef_gain   = RST_GAIN;
   logic signed [HIST_W-1:0] hist_last  [AXES];
   logic signed [HIST_W-1:0] hist_older [AXES];

   sample_beat_t   sample_queue[$];
   filtered_beat_t filtered_queue[$];
   bit             req_taken = 1'b0;
   int             req_gap = 0;
   int             rsp_gap = 0;
   int             idle_rate = 2;
   int             error_count = 0;
   int             cycle_count = 0;

   three_axis_second_order_lowpass_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filtered_x (rsp_filtered_x),
      .rsp_filtered_y (rsp_filtered_y),
      .rsp_filtered_z (rsp_filtered_z),
      .rsp_saturated  (rsp_saturated),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic signed [SW-1:0] lowpass_axis(input int k,
                                                         input logic signed [SW-1:0] x,
                                                         inout logic clip);
      logic signed [95:0] a1, a2, b, y1, y2, xs, sum, hmax, hmin;
      logic signed [HIST_W-1:0] y;
      logic signed [63:0] o, smax;
      a1 = coef_fb_one;
      a2 = coef_fb_two;
      b  = coef_gain;
      y1 = hist_last[k];
      y2 = hist_older[k];
      xs = x;
      sum = a1 * y1 + a2 * y2 + ((b * xs) <<< HFB) + (96'sd1 <<< (CFB - 1));
      sum = sum >>> CFB;
      hmax = (96'sd1 <<< (HIST_W - 1)) - 96'sd1;
      hmin = -hmax - 96'sd1;
      if (sum > hmax) begin
         y = hmax[HIST_W-1:0];
         clip = 1'b1;
      end else if (sum < hmin) begin
         y = hmin[HIST_W-1:0];
         clip = 1'b1;
      end else begin
         y = sum[HIST_W-1:0];
      end
      hist_older[k] = hist_last[k];
      hist_last[k]  = y;
      o = y;
      o = (o + (64'sd1 <<< (HFB - 1))) >>> HFB;
      smax = (64'sd1 <<< (SW - 1)) - 64'sd1;
      if (o > smax) begin
         o = smax;
         clip = 1'b1;
      end else if (o < -smax - 64'sd1) begin
         o = -smax - 64'sd1;
         clip = 1'b1;
      end
      return o[SW-1:0];
   endfunction

   function automatic filtered_beat_t filter_predict(input sample_beat_t s);
      filtered_beat_t r;
      logic clip;
      clip = 1'b0;
      r.x = lowpass_axis(0, s.x, clip);
      r.y = lowpass_axis(1, s.y, clip);
      r.z = lowpass_axis(2, s.z, clip);
      r.sat = clip;
      return r;
   endfunction

   function automatic logic signed [SW-1:0] pick_level();
      case ($urandom_range(0, 3))
         0: return {1'b0, {(SW-1){1'b1}}};
         1: return {1'b1, {(SW-1){1'b0}}};
         default: return SW'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      error_count++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
   endtask

   task automatic push_sample(input int x, input int y, input int z);
      sample_beat_t s;
      s.x = SW'(x);
      s.y = SW'(y);
      s.z = SW'(z);
      sample_queue.push_back(s);
   endtask

   // Mostly held levels with a little noise, as a settling sensor gives; the rest is raw noise.
   task automatic queue_random(input int count);
      int run_left;
      sample_beat_t level, s;
      run_left = 0;
      level = '0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0 && $urandom_range(0, 9) < 3) begin
            s = {SW'($urandom), SW'($urandom), SW'($urandom)};
         end else begin
            if (run_left == 0) begin
               level.x = pick_level();
               level.y = pick_level();
               level.z = pick_level();
               run_left = $urandom_range(5, 40);
            end
            run_left--;
            s.x = level.x ^ SW'($urandom_range(0, 7));
            s.y = level.y ^ SW'($urandom_range(0, 7));
            s.z = level.z ^ SW'($urandom_range(0, 7));
         end
         sample_queue.push_back(s);
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || filtered_queue.size() != 0);
      repeat (4) @(negedge clock);
      idle_rate = $urandom_range(0, 4);
   endtask

   task automatic coef_write(input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr[CSR_ADDR_W-1:2])
         REG_FB_ONE: coef_fb_one = value;
         REG_FB_TWO: coef_fb_two = value;
         REG_GAIN:   coef_gain   = value;
         default: ;
      endcase
      if (addr != SPARE_ADDR) begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_paddr   <= addr;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock);
         while (!csr_pready);
         if (csr_prdata !== value)
            report_mismatch("register read-back", value, csr_prdata);
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   task automatic coef_set(input logic [CSR_DATA_W-1:0] fb_one,
                           input logic [CSR_DATA_W-1:0] fb_two,
                           input logic [CSR_DATA_W-1:0] gain);
      coef_write({REG_FB_ONE, 2'b00}, fb_one);
      coef_write({REG_FB_TWO, 2'b00}, fb_two);
      coef_write({REG_GAIN, 2'b00}, gain);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            sample_beat_t s;
            s = sample_queue.pop_front();
            req_sample_x <= s.x;
            req_sample_y <= s.y;
            req_sample_z <= s.z;
            req_valid    <= 1'b1;
            if ($urandom_range(0, 15) < idle_rate)
               req_gap = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 15) < idle_rate) begin
         rsp_gap = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      sample_beat_t seen;
      filtered_beat_t want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_queue.size() == 0) begin
               error_count++;
               $display("%0t result beat with nothing expected: %0d %0d %0d %0b", $time,
                        rsp_filtered_x, rsp_filtered_y, rsp_filtered_z, rsp_saturated);
            end else begin
               want = filtered_queue.pop_front();
               if (rsp_filtered_x !== want.x) report_mismatch("filtered_x", want.x, rsp_filtered_x);
               if (rsp_filtered_y !== want.y) report_mismatch("filtered_y", want.y, rsp_filtered_y);
               if (rsp_filtered_z !== want.z) report_mismatch("filtered_z", want.z, rsp_filtered_z);
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", want.sat, rsp_saturated);
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            seen.x = req_sample_x;
            seen.y = req_sample_y;
            seen.z = req_sample_z;
            filtered_queue.push_back(filter_predict(seen));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < AXES; k++) begin
         hist_last[k]  = '0;
         hist_older[k] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset coefficients: field extremes, then a full-scale step.
      push_sample(32767, -32768, 0);
      push_sample(-32768, 32767, -1);
      push_sample(1, -1, 16'h5555);
      push_sample(16'hAAAA, 0, 32767);
      push_sample(0, 0, 0);
      repeat (14) push_sample(32767, 32767, -32768);
      repeat (4) push_sample(-32768, -32768, 32767);
      queue_random(200);

      // Unity gain with no feedback passes samples straight through.
      drain();
      coef_set(32'h0, 32'h0, 32'h4000_0000);
      queue_random(100);

      drain();
      coef_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_random(100);

      // Most negative gain on the most negative sample overflows the history.
      drain();
      coef_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_sample(-32768, -32768, -32768);
      push_sample(-32768, 32767, -32768);
      queue_random(100);

      drain();
      coef_set(32'h0, 32'h0, 32'h0);
      queue_random(50);

      drain();
      coef_set($urandom_range(0, 32'h4000_0000), -$urandom_range(0, 32'h2000_0000),
               $urandom_range(0, 32'h0100_0000));
      queue_random(100);

      repeat (2) begin
         drain();
         coef_set($urandom, $urandom, $urandom);
         queue_random(100);
      end

      // A write to the spare address must leave every coefficient alone.
      drain();
      coef_set(RST_FB_ONE, RST_FB_TWO, RST_GAIN);
      coef_write(SPARE_ADDR, $urandom);
      idle_rate = 0;
      queue_random(300);
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || filtered_queue.size() != 0);
      idle_rate = 0;
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
